>>> hw/rtl/taxid_pkg.sv
// Shared types, constants and a helper function for the tax id check-digit validator.
// No dependencies.

package taxid_pkg;

    localparam int unsigned CountW = 4;
    localparam int unsigned SumW   = 10;
    localparam int unsigned DigitW = 4;

    localparam logic [CountW-1:0] CPF_LEN   = 4'd11;
    localparam logic [CountW-1:0] CNPJ_LEN  = 4'd14;
    localparam logic [CountW-1:0] COUNT_MAX = 4'd15;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [3:0] CNPJ_W1 [12] = '{4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8,
                                            4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2};
    localparam logic [3:0] CNPJ_W2 [13] = '{4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8,
                                            4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2};

    typedef enum logic [2:0] {
        VERDICT_OK         = 3'd0,
        VERDICT_BAD_LENGTH = 3'd1,
        VERDICT_ALL_EQUAL  = 3'd2,
        VERDICT_BAD_FIRST  = 3'd3,
        VERDICT_BAD_SECOND = 3'd4
    } verdict_t;

    typedef enum logic {
        KIND_CPF  = 1'b0,
        KIND_CNPJ = 1'b1
    } id_kind_t;

    // final accumulator state of one string
    typedef struct packed {
        logic [CountW-1:0] digit_count;
        logic [SumW-1:0]   first_sum;
        logic [SumW-1:0]   second_sum;
        logic              all_equal;
        logic [DigitW-1:0] first_check_seen;
        logic [DigitW-1:0] second_check_seen;
    } snapshot_t;

    // mod-11 check digit of a 10-bit sum; quotient by reciprocal, one correction
    function automatic logic [DigitW-1:0] check_of(input logic [SumW-1:0] sum);
        logic [16:0] prod;
        logic [6:0]  quot;
        logic [10:0] rem;
        begin
            prod = 17'(sum) * 17'd93;
            quot = prod[16:10];
            rem  = 11'(sum) - 11'(quot) * 11'd11;
            if (rem >= 11'd11)
            begin
                rem = rem - 11'd11;
            end
            if (rem < 11'd2)
            begin
                check_of = '0;
            end
            else
            begin
                check_of = 4'(11'd11 - rem);
            end
        end
    endfunction

endpackage

>>> hw/rtl/taxid_accum.sv
// Per-digit accumulator: digit count, equality tracking, weighted sums, check digits.
// Depends on taxid_pkg.

module taxid_accum
    import taxid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      beat_valid,
    input  logic [7:0] char_code,
    input  logic      is_last,
    input  logic      id_kind,
    output logic      snap_valid,
    output snapshot_t snap
);

    logic [CountW-1:0] digit_count_reg, digit_count_next;
    logic [SumW-1:0]   first_sum_reg, first_sum_next;
    logic [SumW-1:0]   second_sum_reg, second_sum_next;
    logic [DigitW-1:0] leading_digit_reg, leading_digit_next;
    logic              all_equal_reg, all_equal_next;
    logic [DigitW-1:0] first_seen_reg, first_seen_next;
    logic [DigitW-1:0] second_seen_reg, second_seen_next;
    logic              snap_valid_reg;
    snapshot_t         snap_reg;

    logic              is_digit;
    logic [DigitW-1:0] digit;
    logic [3:0]        w1;
    logic [3:0]        w2;
    logic [7:0]        p1;
    logic [7:0]        p2;
    logic [CountW-1:0] k;

    always_comb
    begin
        is_digit = char_code inside {[CHAR_ZERO:CHAR_NINE]};
        digit    = DigitW'(char_code - CHAR_ZERO);
        k        = digit_count_reg;
        w1       = '0;
        w2       = '0;

        digit_count_next   = digit_count_reg;
        first_sum_next     = first_sum_reg;
        second_sum_next    = second_sum_reg;
        leading_digit_next = leading_digit_reg;
        all_equal_next     = all_equal_reg;
        first_seen_next    = first_seen_reg;
        second_seen_next   = second_seen_reg;

        if (id_kind == KIND_CPF)
        begin
            if (k < 4'd9)
            begin
                w1 = 4'd10 - k;
            end
            if (k < 4'd10)
            begin
                w2 = 4'd11 - k;
            end
        end
        else
        begin
            if (k < 4'd12)
            begin
                w1 = CNPJ_W1[k];
            end
            if (k < 4'd13)
            begin
                w2 = CNPJ_W2[k];
            end
        end

        p1 = {4'b0, w1} * {4'b0, digit};
        p2 = {4'b0, w2} * {4'b0, digit};

        if (is_digit)
        begin
            if (k == '0)
            begin
                leading_digit_next = digit;
            end
            else if (digit != leading_digit_reg)
            begin
                all_equal_next = 1'b0;
            end
            if (id_kind == KIND_CPF)
            begin
                if (k == 4'd9)
                begin
                    first_seen_next = digit;
                end
                if (k == 4'd10)
                begin
                    second_seen_next = digit;
                end
            end
            else
            begin
                if (k == 4'd12)
                begin
                    first_seen_next = digit;
                end
                if (k == 4'd13)
                begin
                    second_seen_next = digit;
                end
            end
            first_sum_next  = first_sum_reg + SumW'(p1);
            second_sum_next = second_sum_reg + SumW'(p2);
            if (digit_count_reg < COUNT_MAX)
            begin
                digit_count_next = digit_count_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg   <= '0;
            first_sum_reg     <= '0;
            second_sum_reg    <= '0;
            leading_digit_reg <= '0;
            all_equal_reg     <= 1'b1;
            first_seen_reg    <= '0;
            second_seen_reg   <= '0;
            snap_valid_reg    <= 1'b0;
        end
        else if (en)
        begin
            snap_valid_reg <= beat_valid && is_last;
            if (beat_valid)
            begin
                if (is_last)
                begin
                    digit_count_reg   <= '0;
                    first_sum_reg     <= '0;
                    second_sum_reg    <= '0;
                    leading_digit_reg <= '0;
                    all_equal_reg     <= 1'b1;
                    first_seen_reg    <= '0;
                    second_seen_reg   <= '0;
                end
                else
                begin
                    digit_count_reg   <= digit_count_next;
                    first_sum_reg     <= first_sum_next;
                    second_sum_reg    <= second_sum_next;
                    leading_digit_reg <= leading_digit_next;
                    all_equal_reg     <= all_equal_next;
                    first_seen_reg    <= first_seen_next;
                    second_seen_reg   <= second_seen_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && beat_valid && is_last)
        begin
            snap_reg.digit_count       <= digit_count_next;
            snap_reg.first_sum         <= first_sum_next;
            snap_reg.second_sum        <= second_sum_next;
            snap_reg.all_equal         <= all_equal_next;
            snap_reg.first_check_seen  <= first_seen_next;
            snap_reg.second_check_seen <= second_seen_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

>>> hw/rtl/tax_id_mod11_check_digit_validator_core.sv
// A tlast beat passes the input, snapshot and output registers to m_tvalid.
// Throughput: one input beat per cycle; the pipeline stalls only while a verdict waits.
// Reset (rst_n low, async): pipeline empty, accumulators cleared, id_kind = 0 (CPF).
// A verdict clears the accumulators but keeps id_kind.
// Top level of the mod-11 tax id validator; depends on taxid_pkg and taxid_accum.

module tax_id_mod11_check_digit_validator_core
    import taxid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // id_kind
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] char_code
    input  logic       s_tlast,       // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata        // [0] is_valid, [3:1] verdict_code, [7:4] zero
);

    logic       id_kind_reg;
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       out_valid_reg;
    logic       out_ok_reg;
    verdict_t   out_code_reg;
    verdict_t   code_next;
    logic       en;
    logic       snap_valid;
    snapshot_t  snap;
    logic [CountW-1:0] want_len;

    assign en = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_kind_reg <= KIND_CPF;
        end
        else if (cfg_wr_en)
        begin
            id_kind_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg  <= s_tvalid;
            out_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            char_reg     <= s_tdata;
            last_reg     <= s_tlast;
            out_ok_reg   <= (code_next == VERDICT_OK);
            out_code_reg <= code_next;
        end
    end

    taxid_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .beat_valid (in_valid_reg),
        .char_code  (char_reg),
        .is_last    (last_reg),
        .id_kind    (id_kind_reg),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    always_comb
    begin
        want_len = (id_kind_reg == KIND_CNPJ) ? CNPJ_LEN : CPF_LEN;
        if (snap.digit_count != want_len)
        begin
            code_next = VERDICT_BAD_LENGTH;
        end
        else if (snap.all_equal)
        begin
            code_next = VERDICT_ALL_EQUAL;
        end
        else if (check_of(snap.first_sum) != snap.first_check_seen)
        begin
            code_next = VERDICT_BAD_FIRST;
        end
        else if (check_of(snap.second_sum) != snap.second_check_seen)
        begin
            code_next = VERDICT_BAD_SECOND;
        end
        else
        begin
            code_next = VERDICT_OK;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_code_reg, out_ok_reg};

endmodule
